// File: rtl/core/bqbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqbp_pkg
// Shared constants for the band-pass biquad: default widths and the
// register map of the coefficient port.
// ----------------------------------------------------------------------------
package bqbp_pkg;

    // Default sample width, signed Q1.(SAMPLE_BITS-1)
    localparam int SAMPLE_BITS_DEF = 24;
    // Default coefficient width, signed Q3.(COEF_BITS-3)
    localparam int COEF_BITS_DEF   = 26;

    // Register indexes on the coefficient port
    localparam int          REG_IDX_W     = 2;
    localparam logic [1:0]  REG_FEED_ZERO = 2'd0;
    localparam logic [1:0]  REG_FEED_TWO  = 2'd1;
    localparam logic [1:0]  REG_BACK_ONE  = 2'd2;
    localparam logic [1:0]  REG_BACK_TWO  = 2'd3;

endpackage

// File: rtl/core/bqbp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqbp_core
// Filter arithmetic for one sample: four products summed at full width,
// arithmetic shift back to sample format, overflow zeroing and clip of +1.0.
// ----------------------------------------------------------------------------
module bqbp_core #(
    parameter int SAMPLE_BITS = bqbp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqbp_pkg::COEF_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_x_d2,
    input  logic signed [SAMPLE_BITS-1:0] i_y_d1,
    input  logic signed [SAMPLE_BITS-1:0] i_y_d2,
    input  logic signed [COEF_BITS-1:0]   i_a0,
    input  logic signed [COEF_BITS-1:0]   i_a2,
    input  logic signed [COEF_BITS-1:0]   i_b1,
    input  logic signed [COEF_BITS-1:0]   i_b2,
    output logic signed [SAMPLE_BITS-1:0] o_y,
    output logic                          o_ovf
);

    localparam int OPND_W = SAMPLE_BITS + 1;
    localparam int PROD_W = OPND_W + COEF_BITS;
    localparam int ACC_W  = PROD_W + 2;
    localparam int FRAC   = COEF_BITS - 3;

    localparam logic signed [ACC_W-1:0] ONE     = ACC_W'(1) <<< (SAMPLE_BITS - 1);
    localparam logic signed [ACC_W-1:0] NEG_ONE = -ONE;

    logic signed [OPND_W-1:0] x_e, x_d2_e, y_d1_n, y_d2_n;
    logic signed [PROD_W-1:0] p_a0, p_a2, p_b1, p_b2;
    logic signed [ACC_W-1:0]  acc, y_w;

    // Widen operands; feedback terms enter negated
    assign x_e    = OPND_W'(i_x);
    assign x_d2_e = OPND_W'(i_x_d2);
    assign y_d1_n = -OPND_W'(i_y_d1);
    assign y_d2_n = -OPND_W'(i_y_d2);

    // Exact products
    assign p_a0 = PROD_W'(x_e)    * PROD_W'(i_a0);
    assign p_a2 = PROD_W'(x_d2_e) * PROD_W'(i_a2);
    assign p_b1 = PROD_W'(y_d1_n) * PROD_W'(i_b1);
    assign p_b2 = PROD_W'(y_d2_n) * PROD_W'(i_b2);

    // Sum, then floor shift back to the sample scale
    assign acc = ACC_W'(p_a0) + ACC_W'(p_a2) + ACC_W'(p_b1) + ACC_W'(p_b2);
    assign y_w = acc >>> FRAC;

    // Zero on overflow, clip exactly +1.0 to the largest code
    always_comb begin
        o_ovf = 1'b0;
        if (y_w > ONE || y_w < NEG_ONE) begin
            o_y   = '0;
            o_ovf = 1'b1;
        end else if (y_w == ONE) begin
            o_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            o_y = y_w[SAMPLE_BITS-1:0];
        end
    end

endmodule

// File: rtl/core/biquad_bandpass_with_overflow_reset_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_bandpass_with_overflow_reset_unit
// The input register loads at the input transfer, the result register when
// that sample advances, which waits while a stalled result is held.
// Throughput: one sample per cycle unless results stall, set by the loop
// from the output delays through the multipliers and adder back to them.
// Reset: synchronous active low; clears coefficients, delay lines, valids.
// ----------------------------------------------------------------------------
// Direct-form-I band-pass biquad with overflow reset of the previous output.
// ----------------------------------------------------------------------------
module biquad_bandpass_with_overflow_reset_unit #(
    parameter int SAMPLE_BITS = bqbp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqbp_pkg::COEF_BITS_DEF,
    localparam int DATA_W     = (COEF_BITS > 32) ? 64 : 32,
    localparam int IDX_LSB    = (COEF_BITS > 32) ? 3 : 2,
    localparam int ADDR_W     = IDX_LSB + bqbp_pkg::REG_IDX_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sample input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_overflowed,
    // Coefficient port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    logic signed [COEF_BITS-1:0]   r_a0, r_a2, r_b1, r_b2;
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_x_d1, r_x_d2, r_y_d1, r_y_d2;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic                          r_ovf;

    logic                          in_xfer, advance, cfg_wr;
    logic [bqbp_pkg::REG_IDX_W-1:0] reg_idx;
    logic signed [SAMPLE_BITS-1:0] n_y;
    logic                          n_ovf;

    // Handshake
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Coefficient port decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:IDX_LSB];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0 <= '0;
            r_a2 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bqbp_pkg::REG_FEED_ZERO: r_a0 <= pwdata[COEF_BITS-1:0];
                bqbp_pkg::REG_FEED_TWO:  r_a2 <= pwdata[COEF_BITS-1:0];
                bqbp_pkg::REG_BACK_ONE:  r_b1 <= pwdata[COEF_BITS-1:0];
                bqbp_pkg::REG_BACK_TWO:  r_b2 <= pwdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back, sign extended
    always_comb begin
        unique case (reg_idx)
            bqbp_pkg::REG_FEED_ZERO: prdata = DATA_W'(r_a0);
            bqbp_pkg::REG_FEED_TWO:  prdata = DATA_W'(r_a2);
            bqbp_pkg::REG_BACK_ONE:  prdata = DATA_W'(r_b1);
            bqbp_pkg::REG_BACK_TWO:  prdata = DATA_W'(r_b2);
            default:                 prdata = '0;
        endcase
    end

    // Input register: load on transfer, drop once passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= i_sample_in;
        end
    end

    bqbp_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_core (
        .i_x    (r_x),
        .i_x_d2 (r_x_d2),
        .i_y_d1 (r_y_d1),
        .i_y_d2 (r_y_d2),
        .i_a0   (r_a0),
        .i_a2   (r_a2),
        .i_b1   (r_b1),
        .i_b2   (r_b2),
        .o_y    (n_y),
        .o_ovf  (n_ovf)
    );

    // Result register and delay lines advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_x_d1      <= '0;
            r_x_d2      <= '0;
            r_y_d1      <= '0;
            r_y_d2      <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_x_d1      <= r_x;
            r_x_d2      <= r_x_d1;
            r_y_d1      <= n_y;
            r_y_d2      <= r_y_d1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_y   <= n_y;
            r_ovf <= n_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_y;
    assign o_overflowed = r_ovf;

endmodule

// File: rtl/core/bqbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqbp_checker
// Port-level checks on the biquad: reset, output hold, back pressure,
// overflow zeroing.
// ----------------------------------------------------------------------------
module bqbp_checker #(
    parameter int SAMPLE_BITS = bqbp_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [SAMPLE_BITS-1:0] o_sample_out,
    input logic                   o_overflowed
);

    // No result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out)
            && $stable(o_overflowed))
        else $error("stalled result changed");

    // Input stalls only while a result is waiting
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with room in the result register");

    // Overflowed results are zero
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflowed |-> o_sample_out == '0)
        else $error("overflowed result not zero");

    // A stalled input is released when the result side does not stall
    a_stall_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall && !i_out_stall |=> !o_in_stall)
        else $error("input stall held without back pressure");

endmodule

bind biquad_bandpass_with_overflow_reset_unit bqbp_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bqbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out),
    .o_overflowed (o_overflowed)
);

// File: test/biquad_bandpass_with_overflow_reset_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_bandpass_with_overflow_reset_unit_checker
// Watches the sample, result and coefficient ports of the band-pass biquad.
// Keeps its own copy of the gains and the delay lines, computes the filtered
// sample for every accepted input and compares it field by field against the
// results in the order they leave the block.
// ----------------------------------------------------------------------------
module biquad_bandpass_with_overflow_reset_unit_checker
    import bqbp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF,
    parameter int ADDR_W      = 2 + REG_IDX_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_out,
    input  logic                          i_overflowed,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [ADDR_W-1:0]             i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int     FRAC_BITS = COEF_BITS - 3;
    localparam longint UNITY     = longint'(1) <<< (SAMPLE_BITS - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          overflowed;
    } filtered_sample_t;

    // Gains as last written on the coefficient port
    logic signed [COEF_BITS-1:0]   gain_x0, gain_x2, gain_y1, gain_y2;
    // Past inputs and past outputs of the filter
    logic signed [SAMPLE_BITS-1:0] hist_x1, hist_x2, hist_y1, hist_y2;

    filtered_sample_t filtered_q[$];
    int fail_count;

    assign o_fail_count = fail_count;

    task automatic flag_error(input string msg);
        if (fail_count < 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        fail_count++;
    endtask

    // One filter step: exact sum of products, floor shift, overflow handling
    function automatic filtered_sample_t run_biquad(input logic signed [SAMPLE_BITS-1:0] x);
        longint           acc;
        longint           y;
        filtered_sample_t res;
        acc = longint'(gain_x0) * longint'(x)
            + longint'(gain_x2) * longint'(hist_x2)
            - longint'(gain_y1) * longint'(hist_y1)
            - longint'(gain_y2) * longint'(hist_y2);
        y = acc >>> FRAC_BITS;
        res.overflowed = 1'b0;
        if (y > UNITY || y < -UNITY) begin
            // Magnitude above one: zero the output and the stored previous output
            y = 0;
            res.overflowed = 1'b1;
        end else if (y == UNITY) begin
            // Plus one is not representable: saturate
            y = UNITY - 1;
        end
        res.sample = y[SAMPLE_BITS-1:0];
        hist_x2 = hist_x1;
        hist_x1 = x;
        hist_y2 = hist_y1;
        hist_y1 = res.sample;
        return res;
    endfunction

    // Track writes and transfers; compare every result with the oldest prediction
    always @(posedge i_clk) begin
        filtered_sample_t want;
        if (!i_rst_n) begin
            gain_x0 = '0;
            gain_x2 = '0;
            gain_y1 = '0;
            gain_y2 = '0;
            hist_x1 = '0;
            hist_x2 = '0;
            hist_y1 = '0;
            hist_y2 = '0;
            filtered_q.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_FEED_ZERO: gain_x0 = i_pwdata[COEF_BITS-1:0];
                    REG_FEED_TWO:  gain_x2 = i_pwdata[COEF_BITS-1:0];
                    REG_BACK_ONE:  gain_y1 = i_pwdata[COEF_BITS-1:0];
                    REG_BACK_TWO:  gain_y2 = i_pwdata[COEF_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    flag_error($sformatf("result with none expected: sample_out=%0d overflowed=%0b",
                                         i_sample_out, i_overflowed));
                end else begin
                    want = filtered_q.pop_front();
                    if (i_sample_out !== want.sample) begin
                        flag_error($sformatf("sample_out expected %0d got %0d",
                                             want.sample, i_sample_out));
                    end
                    if (i_overflowed !== want.overflowed) begin
                        flag_error($sformatf("overflowed expected %0b got %0b",
                                             want.overflowed, i_overflowed));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                filtered_q.push_back(run_biquad(i_sample_in));
            end
            o_pending <= filtered_q.size();
        end
    end

    initial fail_count = 0;

endmodule

// File: test/biquad_bandpass_with_overflow_reset_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_bandpass_with_overflow_reset_unit_tb
// Drives the band-pass biquad with directed corner samples (exact plus and
// minus one, overflow in both directions, overflow clearing the feedback
// state, floor rounding) and then with random phases of gains and samples,
// idling both channels at random. A checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module biquad_bandpass_with_overflow_reset_unit_tb;
    import bqbp_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int CB           = COEF_BITS_DEF;
    localparam int ADDR_W       = 2 + REG_IDX_W;
    localparam int RANDOM_ITEMS = 1930;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 500000;

    localparam logic signed [SB-1:0] S_MAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN  = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] S_HALF = SB'(1) <<< (SB - 2);
    localparam logic signed [CB-1:0] C_MAX  = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN  = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] C_ONE  = CB'(1) <<< (CB - 3);
    localparam logic signed [CB-1:0] C_TWO  = CB'(1) <<< (CB - 2);

    typedef enum int {STYLE_RANDOM, STYLE_RESONANT, STYLE_EXTREME, STYLE_GENTLE} phase_style_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [SB-1:0] i_sample_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [SB-1:0] o_sample_out;
    logic                 o_overflowed;
    logic                 psel, penable, pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    int  fail_count;
    int  pending;
    int  cycle_count;
    int  stall_left;
    bit  tx_quiet;
    bit  rx_quiet;

    biquad_bandpass_with_overflow_reset_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_overflowed (o_overflowed),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    biquad_bandpass_with_overflow_reset_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_sample_out (o_sample_out),
        .i_overflowed (o_overflowed),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("biquad_bandpass_with_overflow_reset_unit test failed");
            $finish;
        end
    end

    // Result side: after each transfer stall at random, never while rx_quiet
    always @(posedge i_clk) begin
        int unsigned hold;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_left != 1);
        end else if (o_out_valid && !i_out_stall) begin
            hold = rx_quiet ? 0 : $urandom_range(0, 7);
            stall_left  <= hold;
            i_out_stall <= (hold != 0);
        end
    end

    // Coefficient write: setup cycle, access until pready, then idle
    task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic signed [CB-1:0] gain);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:CB], gain};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_gains(input logic signed [CB-1:0] a0, input logic signed [CB-1:0] a2,
                             input logic signed [CB-1:0] b1, input logic signed [CB-1:0] b2);
        write_coef(REG_FEED_ZERO, a0);
        write_coef(REG_FEED_TWO, a2);
        write_coef(REG_BACK_ONE, b1);
        write_coef(REG_BACK_TWO, b2);
    endtask

    // Sample side: idle at random unless tx_quiet, then hold the sample until its transfer
    task automatic send_sample(input logic signed [SB-1:0] x);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has left the block
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] pick_gain(input phase_style_t style);
        logic signed [CB-1:0] g;
        case (style)
            STYLE_EXTREME: begin
                case ($urandom_range(0, 6))
                    0: g = C_MIN;
                    1: g = C_MAX;
                    2: g = '0;
                    3: g = C_ONE;
                    4: g = -C_ONE;
                    5: g = C_TWO;
                    default: g = -C_TWO;
                endcase
            end
            STYLE_GENTLE: g = CB'($urandom_range(0, 1 << (CB - 2)) - (1 << (CB - 3)));
            default:      g = CB'($urandom);
        endcase
        return g;
    endfunction

    function automatic logic signed [SB-1:0] pick_sample(input phase_style_t style);
        logic signed [SB-1:0] s;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 6))
                0: s = S_MAX;
                1: s = S_MIN;
                2: s = '0;
                3: s = -SB'(1);
                4: s = SB'(1);
                5: s = S_HALF;
                default: s = -S_HALF;
            endcase
        end else if (roll < 5 && style != STYLE_EXTREME) begin
            s = SB'($urandom_range(0, 1 << 16) - (1 << 15));
        end else begin
            s = SB'($urandom);
        end
        return s;
    endfunction

    // Gains for one random phase
    task automatic load_phase(input phase_style_t style);
        logic signed [CB-1:0] a0, b1, b2;
        case (style)
            STYLE_RESONANT: begin
                // Band-pass shape: zeros at DC and Nyquist, poles near the unit circle
                a0 = CB'($urandom_range(0, 1 << (CB - 4)) - (1 << (CB - 5)));
                b2 = CB'($urandom_range(1 << (CB - 4), (1 << (CB - 3)) - 1));
                b1 = CB'($urandom_range(0, (1 << (CB - 1)) - (1 << (CB - 6)))
                         - ((1 << (CB - 2)) - (1 << (CB - 7))));
                set_gains(a0, -a0, b1, b2);
            end
            default: set_gains(pick_gain(style), pick_gain(style),
                               pick_gain(style), pick_gain(style));
        endcase
    endtask

    initial begin
        phase_style_t style;
        int           sent;
        int           len;
        bit           quiet;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample_in <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        cycle_count <= 0;
        rx_quiet    <= 1'b0;
        tx_quiet    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gains at reset are zero: output is zero whatever the input
        send_sample(S_MAX);
        drain();

        // Unity gain: pass through, minus one exactly stays
        set_gains(C_ONE, '0, '0, '0);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample('0);
        send_sample(-SB'(1));
        drain();

        // Gain of two: exactly plus one saturates, beyond one overflows
        set_gains(C_TWO, '0, '0, '0);
        send_sample(S_HALF);
        send_sample(-S_HALF);
        send_sample(S_HALF + SB'(1));
        send_sample(-S_HALF - SB'(1));
        drain();

        // Extreme gains on every register
        set_gains(C_MAX, C_MIN, C_MAX, C_MIN);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample(SB'(1));
        drain();

        // Feedback: overflow clears the previous output, second output keeps it
        set_gains(C_ONE, '0, -C_ONE, -(C_ONE >>> 1));
        send_sample(S_HALF);
        send_sample(S_HALF);
        send_sample('0);
        send_sample(SB'(1000));
        drain();

        // Band-pass zeros with small odd inputs: floor rounding of negatives
        set_gains(C_ONE >>> 1, -(C_ONE >>> 1), 26'sd12345, -26'sd777);
        send_sample(-SB'(1));
        send_sample(SB'(3));
        send_sample(-SB'(5));
        send_sample(SB'(7));
        drain();

        // Random phases, each with its own gains and idling mode
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            style    = phase_style_t'($urandom_range(0, 3));
            quiet    = ($urandom_range(0, 3) == 0);
            tx_quiet = quiet;
            rx_quiet <= quiet;
            load_phase(style);
            len = $urandom_range(40, 160);
            for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
                send_sample(pick_sample(style));
                sent++;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("biquad_bandpass_with_overflow_reset_unit test passed");
        end else begin
            $display("biquad_bandpass_with_overflow_reset_unit test failed");
        end
        $finish;
    end

endmodule

// File: biquad_bandpass_with_overflow_reset_unit.f
rtl/core/bqbp_pkg.sv
rtl/core/bqbp_core.sv
rtl/core/biquad_bandpass_with_overflow_reset_unit.sv
rtl/core/bqbp_checker.sv
test/biquad_bandpass_with_overflow_reset_unit_checker.sv
test/biquad_bandpass_with_overflow_reset_unit_tb.sv
